// ----- design/odo_pkg.sv -----
// ----------------------------------------------------------------------------
// odo_pkg: shared types and constants for the wheel odometry block
// Field widths, fixed-point scales, polynomial coefficients and the
// structs that travel between front end, queue, divider and back end.
// ----------------------------------------------------------------------------
`default_nettype none

package odo_pkg;

  // fraction bits of the internal position accumulators
  localparam int POS_FRAC_BITS = 32;
  localparam int TRAV_SHIFT    = 56 - POS_FRAC_BITS;
  localparam int POS_SHIFT     = POS_FRAC_BITS - 16;

  // trig values are Q30; scaling a 64-bit value splits at bit 32
  localparam int TRIG_FRAC      = 30;
  localparam int RATE_SHIFT     = 24;
  localparam int LIN_DIV_SHIFT  = 16;

  // stream payload widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 160;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RADIUS     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_SEPARATION = 1'b1;
  localparam logic [15:0] RADIUS_RST = 16'd6554;
  localparam logic [17:0] SEP_RST    = 18'd32768;

  // encoder wrap handling
  localparam logic signed [16:0] ENC_WRAP = 17'sd65533;
  localparam logic signed [16:0] ENC_HALF = 17'sd32766;

  // arithmetic constants
  localparam logic [31:0] TRAVEL_K  = 32'd959504903;   // pi * 2^40 / 3600
  localparam logic [31:0] RATE_K    = 32'd1608495439;  // pi * 512e6
  localparam logic [31:0] SEP_SCALE = 32'd3600;
  localparam logic [31:0] VEL_SCALE = 32'd1000000;
  localparam logic [30:0] QUARTER   = 31'h4000_0000;

  // odd sine series, innermost coefficient first
  localparam logic [31:0] SIN_SEED = 32'd172272;
  localparam logic [31:0] SIN_COEF [4] = '{
    32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
  };

  // queue between front end and back end
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  // divider
  localparam int DIV_STEPS = 64;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // one classified sample, ready for the back end
  typedef struct packed {
    logic               upd;   // pose and velocity get updated
    logic signed [15:0] dl;    // left wheel change
    logic signed [15:0] dr;    // right wheel change, negated
    logic [31:0]        t;     // elapsed time
  } odo_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } odo_fifo_st_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } odo_div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } odo_div_rsp_t;

endpackage

`default_nettype wire

// ----- design/odo_front.sv -----
// ----------------------------------------------------------------------------
// odo_front: sample intake
// Accepts encoder beats, forms both wheel changes against the stored
// angles with wrap folding, flags whether the pose moves, and queues it.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_front
  import odo_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [IN_TDATA_W-1:0] s_tdata_i,   // left_position, right_position, elapsed_time
  input  odo_fifo_st_t          fifo_st_i,
  output logic                  push_o,
  output odo_cmd_t              cmd_o
);

  logic [15:0] last_l_q, last_l_d;
  logic [15:0] last_r_q, last_r_d;
  logic        primed_q, primed_d;

  logic [15:0] cur_l, cur_r;
  logic [31:0] cur_t;
  logic signed [15:0] wl, wr;

  // fold a raw difference back into +-32766
  function automatic logic signed [15:0] fold(input logic [15:0] prev, input logic [15:0] cur);
    logic signed [16:0] d;
    d = $signed({1'b0, cur}) - $signed({1'b0, prev});
    if (d > ENC_HALF) begin
      d = d - ENC_WRAP;
    end else if (d < -ENC_HALF) begin
      d = d + ENC_WRAP;
    end
    return d[15:0];
  endfunction

  assign cur_l = s_tdata_i[15:0];
  assign cur_r = s_tdata_i[31:16];
  assign cur_t = s_tdata_i[63:32];

  assign s_tready_o = !fifo_st_i.full;
  assign push_o     = s_tvalid_i && !fifo_st_i.full;

  assign wl = fold(last_l_q, cur_l);
  assign wr = fold(last_r_q, cur_r);

  // classify the beat
  always_comb begin
    cmd_o.upd = primed_q && (cur_t != 32'd0);
    cmd_o.dl  = wl;
    cmd_o.dr  = 16'sd0 - wr;
    cmd_o.t   = cur_t;
    last_l_d  = push_o ? cur_l : last_l_q;
    last_r_d  = push_o ? cur_r : last_r_q;
    primed_d  = push_o ? 1'b1 : primed_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_l_q <= 16'd0;
      last_r_q <= 16'd0;
      primed_q <= 1'b0;
    end else begin
      last_l_q <= last_l_d;
      last_r_q <= last_r_d;
      primed_q <= primed_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/odo_fifo.sv -----
// ----------------------------------------------------------------------------
// odo_fifo: short command queue
// Decouples sample intake from the arithmetic sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_fifo
  import odo_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  odo_cmd_t     cmd_i,
  input  logic         pop_i,
  output odo_cmd_t     cmd_o,
  output odo_fifo_st_t st_o
);

  odo_cmd_t mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] cnt_q;

  assign st_o.full  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign st_o.empty = (cnt_q == '0);
  assign cmd_o      = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/odo_div.sv -----
// ----------------------------------------------------------------------------
// odo_div: shared radix-2 divider
// 64-bit dividend over 32-bit nonzero divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_div
  import odo_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  odo_div_req_t req_i,
  output odo_div_rsp_t rsp_o
);

  logic              busy_q;
  logic              done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [31:0]       rem_q;
  logic [31:0]       dsr_q;
  logic [63:0]       quo_q;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;

  assign trial = {rem_q, quo_q[63]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = (trial >= {1'b0, dsr_q});

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        dsr_q  <= req_i.divisor;
        quo_q  <= req_i.dividend;
      end else if (busy_q) begin
        // shift in one dividend bit, subtract when it fits
        rem_q <= fits ? diff[31:0] : trial[31:0];
        quo_q <= {quo_q[62:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CW'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/odo_back.sv -----
// ----------------------------------------------------------------------------
// odo_back: odometry sequencer
// Pops queued samples and walks the pose update through one shared
// 32x32 multiplier and the shared divider, then loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_back
  import odo_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  odo_fifo_st_t           fifo_st_i,
  input  odo_cmd_t               cmd_i,
  output logic                   pop_o,
  output odo_div_req_t           div_req_o,
  input  odo_div_rsp_t           div_rsp_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o,
  output logic                   out_user_o
);

  typedef enum logic [5:0] {
    ST_IDLE, ST_PREP, ST_M_MN, ST_M_P, ST_M_DEN, ST_M_PK, ST_DH_GO, ST_DH_WAIT,
    ST_MID, ST_T_RED, ST_T_SQ, ST_T_X2, ST_T_MUL, ST_T_SUB, ST_T_MX, ST_T_FIN,
    ST_X_HI, ST_X_LO, ST_X_MAG, ST_X_ACC, ST_Y_HI, ST_Y_LO, ST_Y_MAG, ST_Y_ACC,
    ST_W_HI, ST_W_LO, ST_W_GO, ST_W_WAIT, ST_L_HI, ST_L_LO, ST_L_GO, ST_L_WAIT,
    ST_OUT
  } state_e;

  localparam logic signed [48:0] ACC_MAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] ACC_MIN = 49'sh1_8000_0000_0000;
  localparam logic signed [47:0] OUT_MAX = 48'sd2147483647;
  localparam logic signed [47:0] OUT_MIN = -48'sd2147483648;

  state_e state_q;

  logic [15:0] radius_q;
  logic [17:0] sep_q;
  logic [17:0] sep_eff;

  odo_cmd_t    cmd_q;
  logic [15:0] diffm_q, summ_q;
  logic        diffn_q, sumn_q;
  logic [31:0] mn_q, p_q, den_q;
  logic [63:0] mdh_q;
  logic [46:0] trav_q;
  logic [37:0] trav32_q;
  logic [31:0] mid_q, angle_q;
  logic        pass_q;
  logic [30:0] x_q, x2_q;
  logic        tneg_q;
  logic [31:0] poly_q;
  logic [1:0]  k_q;
  logic [30:0] cosm_q, sinm_q;
  logic        cosn_q, sinn_q;
  logic [63:0] hi_q;
  logic [47:0] stepm_q;
  logic signed [47:0] acc_x_q, acc_y_q;
  logic [31:0] acc_h_q, lin_q, ang_q;
  logic        out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic        out_user_q;
  logic        out_load;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_q;

  logic signed [16:0] diff_s, sum_s;
  logic [16:0] diff_abs, sum_abs;
  logic [31:0] half_s, dh_lo, mid_d;
  logic [30:0] red_x;
  logic [31:0] sin_raw;
  logic [30:0] trig_m;
  logic [63:0] step_full;

  // accumulator step with saturation to 48 bits
  function automatic logic signed [47:0] sat_acc(input logic signed [47:0] acc,
                                                 input logic [47:0] mag, input logic neg);
    logic signed [48:0] st;
    logic signed [48:0] s;
    st = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    s  = $signed({acc[47], acc}) + st;
    if (s > ACC_MAX) begin
      s = ACC_MAX;
    end else if (s < ACC_MIN) begin
      s = ACC_MIN;
    end
    return s[47:0];
  endfunction

  // signed 32-bit velocity from magnitude and sign
  function automatic logic [31:0] sat_vel(input logic [63:0] mag, input logic neg);
    logic [31:0] v;
    if (neg) begin
      v = (mag > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    end else begin
      v = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return v;
  endfunction

  // Q16.16 view of a position accumulator, floored and clamped
  function automatic logic [31:0] pos_out(input logic signed [47:0] acc);
    logic signed [47:0] sh;
    sh = acc >>> POS_SHIFT;
    if (sh > OUT_MAX) begin
      sh = OUT_MAX;
    end else if (sh < OUT_MIN) begin
      sh = OUT_MIN;
    end
    return sh[31:0];
  endfunction

  assign sep_eff = (sep_q == '0) ? 18'd1 : sep_q;

  // per-step arithmetic
  always_comb begin
    diff_s    = 17'(cmd_q.dr) - 17'(cmd_q.dl);
    sum_s     = 17'(cmd_q.dl) + 17'(cmd_q.dr);
    diff_abs  = diff_s[16] ? 17'(-diff_s) : 17'(diff_s);
    sum_abs   = sum_s[16] ? 17'(-sum_s) : 17'(sum_s);
    half_s    = diffn_q ? (32'd0 - mdh_q[32:1]) : mdh_q[32:1];
    dh_lo     = diffn_q ? (32'd0 - mdh_q[31:0]) : mdh_q[31:0];
    mid_d     = acc_h_q + half_s;
    red_x     = angle_q[30] ? (QUARTER - {1'b0, angle_q[29:0]}) : {1'b0, angle_q[29:0]};
    sin_raw   = prod_q[61:30];
    trig_m    = (sin_raw > {1'b0, QUARTER}) ? QUARTER : sin_raw[30:0];
    step_full = (hi_q << (32 - TRIG_FRAC)) + (prod_q >> TRIG_FRAC);
  end

  // multiplier operands and divider requests
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = '0;
    div_req_o.divisor  = cmd_q.t;
    unique case (state_q)
      ST_M_MN: begin
        mul_a = 32'(radius_q);
        mul_b = 32'(diffm_q);
      end
      ST_M_P: begin
        mul_a = 32'(radius_q);
        mul_b = 32'(summ_q);
      end
      ST_M_DEN: begin
        mul_a = SEP_SCALE;
        mul_b = 32'(sep_eff);
      end
      ST_M_PK: begin
        mul_a = p_q;
        mul_b = TRAVEL_K;
      end
      ST_DH_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = {mn_q, 32'd0};
        div_req_o.divisor  = den_q;
      end
      ST_T_SQ: begin
        mul_a = 32'(x_q);
        mul_b = 32'(x_q);
      end
      ST_T_MUL: begin
        mul_a = poly_q;
        mul_b = 32'(x2_q);
      end
      ST_T_MX: begin
        mul_a = poly_q;
        mul_b = 32'(x_q);
      end
      ST_X_HI: begin
        mul_a = 32'(trav_q[46:32]);
        mul_b = 32'(cosm_q);
      end
      ST_X_LO: begin
        mul_a = trav_q[31:0];
        mul_b = 32'(cosm_q);
      end
      ST_Y_HI: begin
        mul_a = 32'(trav_q[46:32]);
        mul_b = 32'(sinm_q);
      end
      ST_Y_LO: begin
        mul_a = trav_q[31:0];
        mul_b = 32'(sinm_q);
      end
      ST_W_HI: begin
        mul_a = mdh_q[63:32];
        mul_b = RATE_K;
      end
      ST_W_LO: begin
        mul_a = mdh_q[31:0];
        mul_b = RATE_K;
      end
      ST_W_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = (hi_q << (32 - RATE_SHIFT)) + (prod_q >> RATE_SHIFT);
      end
      ST_L_HI: begin
        mul_a = 32'(trav32_q[37:32]);
        mul_b = VEL_SCALE;
      end
      ST_L_LO: begin
        mul_a = trav32_q[31:0];
        mul_b = VEL_SCALE;
      end
      ST_L_GO: begin
        div_req_o.start    = 1'b1;
        div_req_o.dividend = ((hi_q << 32) + prod_q) >> LIN_DIV_SHIFT;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign pop_o       = (state_q == ST_IDLE) && !fifo_st_i.empty;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

  // sequencer, state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radius_q    <= RADIUS_RST;
      sep_q       <= SEP_RST;
      cmd_q       <= '0;
      diffm_q     <= '0;
      diffn_q     <= 1'b0;
      summ_q      <= '0;
      sumn_q      <= 1'b0;
      mn_q        <= '0;
      p_q         <= '0;
      den_q       <= '0;
      mdh_q       <= '0;
      trav_q      <= '0;
      trav32_q    <= '0;
      mid_q       <= '0;
      angle_q     <= '0;
      pass_q      <= 1'b0;
      x_q         <= '0;
      x2_q        <= '0;
      tneg_q      <= 1'b0;
      poly_q      <= '0;
      k_q         <= '0;
      cosm_q      <= '0;
      cosn_q      <= 1'b0;
      sinm_q      <= '0;
      sinn_q      <= 1'b0;
      hi_q        <= '0;
      stepm_q     <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
      acc_h_q     <= '0;
      lin_q       <= '0;
      ang_q       <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_user_q  <= 1'b0;
    end else begin
      prod_q <= mul_a * mul_b;

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_WHEEL_RADIUS:     radius_q <= cfg_data_i[15:0];
          CFG_WHEEL_SEPARATION: sep_q    <= cfg_data_i[17:0];
        endcase
      end

      // result register: load a finished beat, clear a taken one
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {ang_q, lin_q, acc_h_q, pos_out(acc_y_q), pos_out(acc_x_q)};
        out_user_q  <= cmd_q.upd;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (!fifo_st_i.empty) begin
            cmd_q   <= cmd_i;
            state_q <= cmd_i.upd ? ST_PREP : ST_OUT;
          end
        end
        ST_PREP: begin
          diffm_q <= diff_abs[15:0];
          diffn_q <= diff_s[16];
          summ_q  <= sum_abs[15:0];
          sumn_q  <= sum_s[16];
          state_q <= ST_M_MN;
        end
        ST_M_MN:  state_q <= ST_M_P;
        ST_M_P: begin
          mn_q    <= prod_q[31:0];
          state_q <= ST_M_DEN;
        end
        ST_M_DEN: begin
          p_q     <= prod_q[31:0];
          state_q <= ST_M_PK;
        end
        ST_M_PK: begin
          den_q   <= prod_q[31:0];
          state_q <= ST_DH_GO;
        end
        ST_DH_GO: begin
          trav_q   <= 47'(prod_q >> TRAV_SHIFT);
          trav32_q <= prod_q[61:24];
          state_q  <= ST_DH_WAIT;
        end
        ST_DH_WAIT: begin
          if (div_rsp_i.done) begin
            mdh_q   <= div_rsp_i.quotient;
            state_q <= ST_MID;
          end
        end
        ST_MID: begin
          // cosine first: sine of the midpoint plus a quarter turn
          mid_q   <= mid_d;
          angle_q <= mid_d + 32'h4000_0000;
          pass_q  <= 1'b0;
          state_q <= ST_T_RED;
        end
        ST_T_RED: begin
          x_q     <= red_x;
          tneg_q  <= angle_q[31];
          state_q <= ST_T_SQ;
        end
        ST_T_SQ:  state_q <= ST_T_X2;
        ST_T_X2: begin
          x2_q    <= prod_q[60:30];
          poly_q  <= SIN_SEED;
          k_q     <= '0;
          state_q <= ST_T_MUL;
        end
        ST_T_MUL: state_q <= ST_T_SUB;
        ST_T_SUB: begin
          poly_q  <= SIN_COEF[k_q] - prod_q[61:30];
          k_q     <= k_q + 1'b1;
          state_q <= (k_q == 2'd3) ? ST_T_MX : ST_T_MUL;
        end
        ST_T_MX:  state_q <= ST_T_FIN;
        ST_T_FIN: begin
          if (!pass_q) begin
            cosm_q  <= trig_m;
            cosn_q  <= tneg_q;
            angle_q <= mid_q;
            pass_q  <= 1'b1;
            state_q <= ST_T_RED;
          end else begin
            sinm_q  <= trig_m;
            sinn_q  <= tneg_q;
            state_q <= ST_X_HI;
          end
        end
        ST_X_HI:  state_q <= ST_X_LO;
        ST_X_LO: begin
          hi_q    <= prod_q;
          state_q <= ST_X_MAG;
        end
        ST_X_MAG: begin
          stepm_q <= step_full[47:0];
          state_q <= ST_X_ACC;
        end
        ST_X_ACC: begin
          acc_x_q <= sat_acc(acc_x_q, stepm_q, sumn_q ^ cosn_q);
          state_q <= ST_Y_HI;
        end
        ST_Y_HI:  state_q <= ST_Y_LO;
        ST_Y_LO: begin
          hi_q    <= prod_q;
          state_q <= ST_Y_MAG;
        end
        ST_Y_MAG: begin
          stepm_q <= step_full[47:0];
          state_q <= ST_Y_ACC;
        end
        ST_Y_ACC: begin
          acc_y_q <= sat_acc(acc_y_q, stepm_q, sumn_q ^ sinn_q);
          state_q <= ST_W_HI;
        end
        ST_W_HI: begin
          acc_h_q <= acc_h_q + dh_lo;
          state_q <= ST_W_LO;
        end
        ST_W_LO: begin
          hi_q    <= prod_q;
          state_q <= ST_W_GO;
        end
        ST_W_GO:  state_q <= ST_W_WAIT;
        ST_W_WAIT: begin
          if (div_rsp_i.done) begin
            ang_q   <= sat_vel(div_rsp_i.quotient, diffn_q);
            state_q <= ST_L_HI;
          end
        end
        ST_L_HI:  state_q <= ST_L_LO;
        ST_L_LO: begin
          hi_q    <= prod_q;
          state_q <= ST_L_GO;
        end
        ST_L_GO:  state_q <= ST_L_WAIT;
        ST_L_WAIT: begin
          if (div_rsp_i.done) begin
            lin_q   <= sat_vel(div_rsp_i.quotient, sumn_q);
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          // leave once the beat is in the result register
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/differential_drive_odometry_top.sv -----
// ----------------------------------------------------------------------------
// differential_drive_odometry_top: differential-drive wheel odometry
// Usage:
//   s_axis carries one encoder sample a beat: left and right wheel angles in
//   tenths of a degree and the microseconds since the previous sample.
//   m_axis returns one pose beat per sample: x, y, heading, linear and
//   angular velocity; tuser is high when the sample moved the pose.
//   cfg_we_i/cfg_index_i/cfg_data_i write wheel radius (index 0) and wheel
//   separation (index 1); write them only while the block is idle.
// Flow:
//   A sample that does not move the pose (first sample, zero time) skips the
//   arithmetic and goes straight to the result register. A moving sample is
//   worked through three passes of the shared radix-2 divider (heading change,
//   angular rate, linear rate) plus the steps of the shared 32x32 multiplier
//   for travel, the sine series and the position scaling.
//   Samples are worked on one at a time; a 4-deep queue keeps s_axis_tready
//   high while the sequencer works or the receiver stalls, until it fills.
// Reset:
//   Clears pose, velocities and stored angles and loads the default radius
//   and separation. A stalled m_axis beat holds until taken; samples back up
//   into the queue and then tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry_top
  import odo_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // left_position, right_position, elapsed_time
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pos_x, pos_y, heading, linear_velocity,
                                                 // angular_velocity
  output logic                   m_axis_tuser,   // updated
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  odo_fifo_st_t fifo_st;
  odo_cmd_t     push_cmd, pop_cmd;
  logic         push, pop;
  odo_div_req_t div_req;
  odo_div_rsp_t div_rsp;

  // intake
  odo_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .fifo_st_i  (fifo_st),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // queue
  odo_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (pop_cmd),
    .st_o   (fifo_st)
  );

  // shared divider
  odo_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer
  odo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fifo_st_i   (fifo_st),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ----- design/odo_checker.sv -----
// ----------------------------------------------------------------------------
// odo_checker: port-level checks for the odometry block
// Watches the result stream: stall behavior, a zero first beat after reset,
// and that samples which do not move the pose repeat the previous pose beat.
// ----------------------------------------------------------------------------
`default_nettype none

module odo_checker
  import odo_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser
);

  logic                   beat;
  logic                   seen_q;
  logic [OUT_TDATA_W-1:0] prev_q;

  assign beat = m_axis_tvalid && m_axis_tready;

  // last delivered pose beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      prev_q <= '0;
    end else if (beat) begin
      seen_q <= 1'b1;
      prev_q <= m_axis_tdata;
    end
  end

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result beat changed while stalled");

  a_first_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && !seen_q) |-> (m_axis_tdata == '0 && !m_axis_tuser))
    else $error("first beat after reset is not the zero pose");

  a_idle_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && seen_q && !m_axis_tuser) |-> (m_axis_tdata == prev_q))
    else $error("pose moved on a sample without update");

endmodule

bind differential_drive_odometry_top odo_checker u_odo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ----- verif/odometry_checker.sv -----
// ----------------------------------------------------------------------------
// odometry_checker: pose predictor and scoreboard for the odometry block
// Watches the sample, pose and configuration channels, keeps its own copy of
// the wheel geometry and pose state, predicts one pose beat per accepted
// sample and compares every delivered pose beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module odometry_checker
  import odo_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // left_position, right_position, elapsed_time
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // pos_x, pos_y, heading, linear_velocity,
                                                 // angular_velocity
  input  logic                   m_axis_tuser,   // updated
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     errors_o,
  output int                     pending_o
);

  // same bit order as {tdata, tuser}: pos_x lowest in tdata
  typedef struct packed {
    logic [31:0] ang_vel;
    logic [31:0] lin_vel;
    logic [31:0] heading;
    logic [31:0] pos_y;
    logic [31:0] pos_x;
    logic        updated;
  } pose_beat_t;

  localparam longint ACC_LIMIT = 64'sh7FFF_FFFF_FFFF;

  pose_beat_t  pose_q[$];

  // model copy of geometry and pose state
  logic [15:0] radius;
  logic [17:0] separation;
  logic [15:0] prev_left, prev_right;
  bit          primed;
  longint      acc_x, acc_y;
  logic [31:0] acc_heading;
  logic [31:0] lin_vel, ang_vel;

  // fold a raw encoder difference across the wrap
  function automatic longint wheel_delta(logic [15:0] prev, logic [15:0] cur);
    longint d;
    d = longint'(cur) - longint'(prev);
    if (d > 32766) d -= 65533;
    else if (d < -32766) d += 65533;
    return d;
  endfunction

  // odd series over one quarter turn, Q30
  function automatic longint unsigned quarter_sin(longint unsigned x);
    longint unsigned x2, p;
    x2 = (x * x) >> 30;
    p  = 64'd172272;
    p  = 64'd5026995    - ((p * x2) >> 30);
    p  = 64'd85569306   - ((p * x2) >> 30);
    p  = 64'd693598668  - ((p * x2) >> 30);
    p  = 64'd1686629713 - ((p * x2) >> 30);
    p  = (p * x) >> 30;
    return (p > 64'h4000_0000) ? 64'h4000_0000 : p;
  endfunction

  function automatic longint bam_sin(logic [31:0] a);
    longint unsigned r, m;
    r = a[29:0];
    if (a[30]) r = 64'h4000_0000 - r;
    m = quarter_sin(r);
    return a[31] ? -longint'(m) : longint'(m);
  endfunction

  // travel times a Q30 trig value, truncated toward zero
  function automatic longint trig_step(longint v, longint s);
    logic [127:0] prod;
    longint unsigned mv, ms;
    longint r;
    mv   = (v < 0) ? -v : v;
    ms   = (s < 0) ? -s : s;
    prod = 128'(mv) * 128'(ms);
    r    = longint'(prod[93:30]);
    return ((v < 0) != (s < 0)) ? -r : r;
  endfunction

  function automatic longint sat_acc(longint v);
    if (v > ACC_LIMIT) return ACC_LIMIT;
    if (v < -ACC_LIMIT - 1) return -ACC_LIMIT - 1;
    return v;
  endfunction

  function automatic logic [31:0] sat_vel(longint unsigned mag, bit neg);
    if (neg) return (mag > 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(mag));
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  function automatic logic [31:0] pos_word(longint acc);
    longint v;
    v = acc >>> POS_SHIFT;
    if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return v[31:0];
  endfunction

  // advance the pose for one sample and build its expected beat
  function automatic pose_beat_t predict_pose(logic [63:0] sample);
    pose_beat_t      b;
    logic [15:0]     left, right;
    longint unsigned t, sep, mn, den, mdh, p, pk, trav32, mw;
    longint          dl, dr, n, sum, dh, trav;
    logic [31:0]     mid;
    logic [127:0]    rate_prod;
    left  = sample[15:0];
    right = sample[31:16];
    t     = sample[63:32];
    b.updated = 1'b0;
    if (primed && t != 0) begin
      dl   = wheel_delta(prev_left, left);
      dr   = -wheel_delta(prev_right, right);
      sep  = (separation == 0) ? 64'd1 : 64'(separation);
      n    = longint'(radius) * (dr - dl);
      sum  = dl + dr;
      mn   = (n < 0) ? -n : n;
      den  = 64'd3600 * sep;
      mdh  = ((mn / den) << 32) + (((mn % den) << 32) / den);
      dh   = (n < 0) ? -longint'(mdh) : longint'(mdh);
      p    = 64'(radius) * 64'((sum < 0) ? -sum : sum);
      pk   = p * 64'(TRAVEL_K);
      trav = longint'(pk >> TRAV_SHIFT);
      trav32 = pk >> 24;
      if (sum < 0) trav = -trav;
      mid   = acc_heading + 32'(dh / 2);
      acc_x = sat_acc(acc_x + trig_step(trav, bam_sin(mid + 32'h4000_0000)));
      acc_y = sat_acc(acc_y + trig_step(trav, bam_sin(mid)));
      acc_heading = acc_heading + 32'(dh);
      lin_vel   = sat_vel((trav32 * 64'd1000000) / (t << 16), sum < 0);
      rate_prod = 128'(mdh) * 128'(RATE_K);
      mw        = rate_prod[87:24] / t;
      ang_vel   = sat_vel(mw, dh < 0);
      b.updated = 1'b1;
    end
    prev_left  = left;
    prev_right = right;
    primed     = 1'b1;
    b.pos_x   = pos_word(acc_x);
    b.pos_y   = pos_word(acc_y);
    b.heading = acc_heading;
    b.lin_vel = lin_vel;
    b.ang_vel = ang_vel;
    return b;
  endfunction

  // channel monitor: predict on sample beats, compare on pose beats
  always @(posedge clk_i or negedge rst_ni) begin
    pose_beat_t exp_b, got_b;
    if (!rst_ni) begin
      radius      = RADIUS_RST;
      separation  = SEP_RST;
      prev_left   = '0;
      prev_right  = '0;
      primed      = 1'b0;
      acc_x       = 0;
      acc_y       = 0;
      acc_heading = '0;
      lin_vel     = '0;
      ang_vel     = '0;
      pose_q.delete();
      errors_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_WHEEL_RADIUS) radius = cfg_data_i[15:0];
        else if (cfg_index_i == CFG_WHEEL_SEPARATION) separation = cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_b = {m_axis_tdata, m_axis_tuser};
        if (pose_q.size() == 0) begin
          $display("%0t: unexpected pose beat %h", $time, got_b);
          errors_o++;
        end else begin
          exp_b = pose_q.pop_front();
          if (got_b.pos_x !== exp_b.pos_x)
            $display("%0t: pos_x exp %h got %h", $time, exp_b.pos_x, got_b.pos_x);
          if (got_b.pos_y !== exp_b.pos_y)
            $display("%0t: pos_y exp %h got %h", $time, exp_b.pos_y, got_b.pos_y);
          if (got_b.heading !== exp_b.heading)
            $display("%0t: heading exp %h got %h", $time, exp_b.heading, got_b.heading);
          if (got_b.lin_vel !== exp_b.lin_vel)
            $display("%0t: linear_velocity exp %h got %h", $time, exp_b.lin_vel,
                     got_b.lin_vel);
          if (got_b.ang_vel !== exp_b.ang_vel)
            $display("%0t: angular_velocity exp %h got %h", $time, exp_b.ang_vel,
                     got_b.ang_vel);
          if (got_b.updated !== exp_b.updated)
            $display("%0t: updated exp %b got %b", $time, exp_b.updated, got_b.updated);
          if (got_b !== exp_b) errors_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pose_q.insert(pose_q.size(), predict_pose(s_axis_tdata));
    end
    pending_o = pose_q.size();
  end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: stimulus for the differential-drive odometry block
// Drives encoder samples through directed corner cases and random wheel
// motion under several wheel geometries and idle patterns, including one
// long output stall; the checker predicts and compares every pose beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import odo_pkg::*;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // left_position, right_position, elapsed_time
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // pos_x, pos_y, heading, linear_velocity,
                                               // angular_velocity
  logic                   m_axis_tuser;        // updated
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  int                     errors, pending;

  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          holdoff_req = 0;
  logic [15:0] enc_left = '0, enc_right = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  differential_drive_odometry_top u_dut (.*);

  odometry_checker u_checker (
    .errors_o (errors),
    .pending_o(pending),
    .*
  );

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int holdoff_seen, hold_left;
    holdoff_seen = 0;
    hold_left    = 0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req != holdoff_seen) begin
        holdoff_seen = holdoff_req;
        hold_left    = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // offer one sample beat and wait for it to be taken
  task automatic send_sample(logic [15:0] left, logic [15:0] right, logic [31:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {dt, right, left};
    enc_left      = left;
    enc_right     = right;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // let every pose beat arrive, then the sequencer settle
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_geometry(logic [15:0] rad, logic [17:0] sep);
    drain();
    cfg_we_i    = 1'b1;
    cfg_index_i = CFG_WHEEL_RADIUS;
    cfg_data_i  = 18'(rad);
    @(negedge clk_i);
    cfg_index_i = CFG_WHEEL_SEPARATION;
    cfg_data_i  = sep;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // random wheel motion: mostly smooth steps, some jumps and wrap crossings
  task automatic random_samples(int count);
    logic [15:0] l, r;
    logic [31:0] dt;
    int          kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        l = enc_left + 16'($urandom_range(4000) - 2000);
        r = enc_right + 16'($urandom_range(4000) - 2000);
      end else if (kind < 85) begin
        l = 16'($urandom);
        r = 16'($urandom);
      end else begin
        l = 16'($urandom_range(65535, 65500));
        r = 16'($urandom_range(40));
      end
      kind = $urandom_range(99);
      if (kind < 5) dt = '0;
      else if (kind < 20) dt = $urandom_range(100, 1);
      else if (kind < 80) dt = $urandom_range(20000, 5000);
      else dt = $urandom;
      send_sample(l, r, dt);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: priming, zero time, wrap folding at both bounds, extreme time
    send_sample(16'd100, 16'd200, 32'd5000);
    send_sample(16'd400, 16'd900, 32'd0);
    send_sample(16'd700, 16'd600, 32'd10000);
    send_sample(16'd65535, 16'd0, 32'd1);
    send_sample(16'd32769, 16'd32766, 32'd1);
    send_sample(16'd0, 16'd65535, 32'd1000);
    send_sample(16'd0, 16'd0, 32'hFFFF_FFFF);
    send_sample(16'd32766, 16'd32766, 32'd1);

    // widest radius, narrowest track: saturated velocities, fast spin
    write_geometry(16'hFFFF, 18'd1);
    send_sample(16'd65532, 16'd0, 32'd1);
    send_sample(16'd32766, 16'd32770, 32'd1);
    send_sample(16'd0, 16'd0, 32'd1);
    send_sample(16'd32766, 16'd32766, 32'hFFFF_FFFF);
    send_sample(16'd0, 16'd32766, 32'd3);

    // zero track width behaves as the narrowest one
    write_geometry(16'd1234, 18'd0);
    send_sample(16'd500, 16'd100, 32'd1);
    send_sample(16'd900, 16'd900, 32'd20);

    // smallest radius, widest track
    write_geometry(16'd1, 18'h3FFFF);
    send_sample(16'd30000, 16'd3000, 32'd7);
    send_sample(16'd100, 16'd65000, 32'd1);

    // random phases, idle patterns rotating
    write_geometry(16'd6554, 18'd32768);
    send_idle_pct = 0;  recv_stall_pct = 0;  random_samples(60);
    send_idle_pct = 71; recv_stall_pct = 0;  random_samples(50);
    send_idle_pct = 0;  recv_stall_pct = 71; random_samples(50);

    write_geometry(16'($urandom_range(65535, 1)), 18'($urandom_range(2000, 1)));
    send_idle_pct = 27; recv_stall_pct = 27; random_samples(60);
    // long output stall while samples keep coming
    send_idle_pct = 0;  recv_stall_pct = 0;
    holdoff_req++;
    random_samples(30);

    write_geometry(16'($urandom), 18'($urandom_range(262143, 1)));
    send_idle_pct = 71; recv_stall_pct = 71; random_samples(40);
    send_idle_pct = 0;  recv_stall_pct = 0;  random_samples(60);

    write_geometry(16'hFFFF, 18'($urandom_range(200, 1)));
    send_idle_pct = 27; recv_stall_pct = 71; random_samples(50);
    send_idle_pct = 0;  recv_stall_pct = 27; random_samples(50);

    drain();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog
  initial begin
    #18_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/odo_pkg.sv
design/odo_front.sv
design/odo_fifo.sv
design/odo_div.sv
design/odo_back.sv
design/differential_drive_odometry_top.sv
design/odo_checker.sv
verif/odometry_checker.sv
verif/testbench.sv
